// ===== src/gba_pkg.sv =====
// Shared constants, types and capacity functions of the grouped bitmap block allocator.
package gba_pkg;

	localparam int MAX_GROUPS       = 16;
	localparam int MAX_GROUP_BLOCKS = 4096;
	localparam int MAP_WORD_BITS    = 64;

	localparam int GRP_W   = $clog2(MAX_GROUPS);
	localparam int GCNT_W  = $clog2(MAX_GROUPS + 1);
	localparam int BIT_W   = $clog2(MAX_GROUP_BLOCKS);
	localparam int CNT_W   = $clog2(MAX_GROUP_BLOCKS + 1);
	localparam int WB_W    = $clog2(MAP_WORD_BITS);
	localparam int WIDX_W  = BIT_W - WB_W;
	localparam int MAP_WORDS = MAX_GROUPS * MAX_GROUP_BLOCKS / MAP_WORD_BITS;
	localparam int MAP_AW  = $clog2(MAP_WORDS);
	localparam int ADDR_W  = 48;
	localparam int TOT_W   = 17;
	localparam int CFG_W   = 48;
	localparam int CIDX_W  = 2;

	// Register indexes of the configuration port.
	localparam logic [CIDX_W-1:0] REG_GROUP_COUNT  = 2'd0;
	localparam logic [CIDX_W-1:0] REG_BLOCKS_PER   = 2'd1;
	localparam logic [CIDX_W-1:0] REG_FIRST_ADDR   = 2'd2;
	localparam logic [CIDX_W-1:0] REG_FINAL_BLOCKS = 2'd3;

	// Request codes.
	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_NO_SPACE    = 2'd1,
		ST_BAD_ADDR    = 2'd2,
		ST_DOUBLE_FREE = 2'd3
	} status_t;

	// Group count in use, clamped to 1..MAX_GROUPS.
	function automatic logic [GCNT_W-1:0] eff_groups(input logic [4:0] gc);
		logic [GCNT_W-1:0] r;
		if (gc == 5'd0) r = GCNT_W'(1);
		else if (32'(gc) > MAX_GROUPS) r = GCNT_W'(MAX_GROUPS);
		else r = GCNT_W'(gc);
		return r;
	endfunction

	// Blocks per group, clamped to 1..MAX_GROUP_BLOCKS.
	function automatic logic [CNT_W-1:0] eff_bpg(input logic [12:0] bpg);
		logic [CNT_W-1:0] r;
		if (bpg == 13'd0) r = CNT_W'(1);
		else if (32'(bpg) > MAX_GROUP_BLOCKS) r = CNT_W'(MAX_GROUP_BLOCKS);
		else r = CNT_W'(bpg);
		return r;
	endfunction

	// Usable blocks of a group; the last group in use may be shorter.
	function automatic logic [CNT_W-1:0] capacity(input logic [GRP_W-1:0] g,
			input logic [GCNT_W-1:0] n, input logic [CNT_W-1:0] bpg,
			input logic [12:0] fgb);
		logic [CNT_W-1:0] r;
		logic [12:0] f;
		f = (fgb == 13'd0) ? 13'd1 : fgb;
		r = bpg;
		if (GCNT_W'(g) + GCNT_W'(1) == n) begin
			if (32'(f) < 32'(bpg)) r = CNT_W'(f);
		end
		return r;
	endfunction

endpackage

// ===== src/gba_if.sv =====
// Request and response channel interfaces of the allocator.
interface gba_req_if;
	import gba_pkg::*;
	logic              valid;
	logic              ready;
	logic              req_type;
	logic [3:0]        start_group;
	logic [ADDR_W-1:0] free_address;
	modport source (output valid, req_type, start_group, free_address, input ready);
	modport sink (input valid, req_type, start_group, free_address, output ready);
endinterface

interface gba_rsp_if;
	import gba_pkg::*;
	logic              valid;
	logic              ready;
	logic [1:0]        status;
	logic [ADDR_W-1:0] granted_address;
	logic [TOT_W-1:0]  free_total;
	modport source (output valid, status, granted_address, free_total, input ready);
	modport sink (input valid, status, granted_address, free_total, output ready);
endinterface

// ===== src/gba_div.sv =====
// Restoring divider, one quotient bit per cycle, that splits an address by the group size.
module gba_div
	import gba_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [ADDR_W-1:0] dividend,
	input  logic [CNT_W-1:0]  divisor,
	output logic              done,
	output logic [ADDR_W-1:0] quotient,
	output logic [CNT_W-1:0]  remainder
);

	localparam int STEP_W = $clog2(ADDR_W);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [ADDR_W-1:0] quo_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  div_q;
	logic [CNT_W:0]    trial;
	logic              ge;

	// Shift the next dividend bit into the partial remainder and try a subtract.
	assign trial = {rem_q, quo_q[ADDR_W-1]};
	assign ge    = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + STEP_W'(1);
				if (cnt_q == STEP_W'(ADDR_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[ADDR_W-2:0], ge};
			rem_q <= ge ? CNT_W'(trial - {1'b0, div_q}) : CNT_W'(trial);
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ===== src/grouped_bitmap_block_allocator.sv =====
// Top level of the grouped bitmap block allocator: sequencer, used map and counters.
//
//  channel | dir | handshake    | payload
//  req     | in  | valid/ready  | req_type, start_group, free_address
//  rsp     | out | valid/ready  | status, granted_address, free_total
//  cfg     | in  | cfg_we only  | cfg_index, cfg_data
//
// An allocate reads the used map one 64-bit word at a time, in S_ARD and then S_ACHK for
// each word scanned, with a pass through S_AGRP for each group visited.
// A free waits on the one-bit-per-cycle divider, then checks and clears its bit.
// Every item ends in S_SUM, which totals the free blocks of each group in use.
// After reset the used map is cleared one word a cycle, all 1024 words, with req.ready low.
// A waiting result holds the sequencer only at its final step.
module grouped_bitmap_block_allocator
	import gba_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	gba_req_if.sink           req,
	gba_rsp_if.source         rsp,
	input  logic              cfg_we,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data
);

	localparam int OFF_W = GRP_W + CNT_W;

	typedef enum logic [11:0] {
		S_CLR  = 12'b000000000001,
		S_IDLE = 12'b000000000010,
		S_AMOD = 12'b000000000100,
		S_AGRP = 12'b000000001000,
		S_ARD  = 12'b000000010000,
		S_ACHK = 12'b000000100000,
		S_DIV  = 12'b000001000000,
		S_FCHK = 12'b000010000000,
		S_FRD  = 12'b000100000000,
		S_FBIT = 12'b001000000000,
		S_SUM  = 12'b010000000000,
		S_FIN  = 12'b100000000000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [4:0]        gc_q;
	logic [12:0]       bpg_q;
	logic [ADDR_W-1:0] fga_q;
	logic [12:0]       fgb_q;

	// Sequencer registers.
	logic [MAP_AW-1:0]  clr_q;
	logic [GRP_W-1:0]   g_q;
	logic [GCNT_W-1:0]  tried_q;
	logic [WIDX_W-1:0]  word_q;
	logic [BIT_W-1:0]   bit_q;
	logic [ADDR_W-1:0]  base_q;
	logic [GCNT_W-1:0]  s_q;
	logic [TOT_W-1:0]   acc_q;
	logic [1:0]         res_status_q;
	logic [ADDR_W-1:0]  res_grant_q;
	logic [CNT_W-1:0]   grp_used_q [MAX_GROUPS];

	// Output register.
	logic               out_valid_q;
	logic [1:0]         out_status_q;
	logic [ADDR_W-1:0]  out_grant_q;
	logic [TOT_W-1:0]   out_total_q;

	// Used map memory.
	logic [MAP_WORD_BITS-1:0] map_mem [MAP_WORDS];
	logic [MAP_WORD_BITS-1:0] rdata_q;
	logic [MAP_AW-1:0]        mem_ra;
	logic [MAP_AW-1:0]        mem_wa;
	logic [MAP_WORD_BITS-1:0] mem_wd;
	logic                     mem_we;

	// Divider hookup.
	logic              div_start;
	logic              div_done;
	logic [ADDR_W-1:0] div_quo;
	logic [CNT_W-1:0]  div_rem;
	logic [ADDR_W-1:0] rel_addr;

	// Shared group view.
	logic [GCNT_W-1:0] n_eff;
	logic [CNT_W-1:0]  bpg_eff;
	logic [GRP_W-1:0]  gidx;
	logic [CNT_W-1:0]  cap_cur;
	logic [CNT_W-1:0]  used_cur;
	logic [CNT_W-1:0]  rem_cap;
	logic              last_word;
	logic [MAP_WORD_BITS-1:0] word_mask;
	logic [MAP_WORD_BITS-1:0] free_bits;
	logic [WB_W-1:0]   low_idx;
	logic              found;
	logic              last_group;
	logic              req_acc;
	logic              quo_ok;
	logic [OFF_W-1:0]  grp_off;

	assign n_eff    = eff_groups(gc_q);
	assign bpg_eff  = eff_bpg(bpg_q);
	assign gidx     = (state_q == S_SUM) ? s_q[GRP_W-1:0] : g_q;
	assign cap_cur  = capacity(gidx, n_eff, bpg_eff, fgb_q);
	assign used_cur = grp_used_q[gidx];
	assign req_acc  = req.valid && req.ready;
	assign rel_addr = req.free_address - fga_q;
	assign last_group = (tried_q + GCNT_W'(1)) == n_eff;
	assign quo_ok   = (div_quo[ADDR_W-1:GRP_W] == '0)
		&& (GCNT_W'(div_quo[GRP_W-1:0]) < n_eff);

	// Offset of the current group from the first group address.
	assign grp_off  = OFF_W'(g_q) * OFF_W'(bpg_eff);

	// Word scan: bits below the group capacity that are clear, lowest first.
	assign rem_cap   = cap_cur - CNT_W'({word_q, {WB_W{1'b0}}});
	assign last_word = (CNT_W'({word_q, {WB_W{1'b0}}}) + CNT_W'(MAP_WORD_BITS)) >= cap_cur;
	always_comb begin
		for (int k = 0; k < MAP_WORD_BITS; k++) begin
			word_mask[k] = CNT_W'(k) < rem_cap;
		end
		free_bits = ~rdata_q & word_mask;
		found     = |free_bits;
		low_idx   = '0;
		for (int k = MAP_WORD_BITS - 1; k >= 0; k--) begin
			if (free_bits[k]) low_idx = WB_W'(k);
		end
	end

	// Memory port selection.
	always_comb begin
		mem_we = 1'b0;
		mem_wa = {g_q, word_q};
		mem_wd = '0;
		mem_ra = {g_q, word_q};
		if (state_q == S_FRD) mem_ra = {g_q, bit_q[BIT_W-1:WB_W]};
		if (state_q == S_CLR) begin
			mem_we = 1'b1;
			mem_wa = clr_q;
		end else if (state_q == S_ACHK && found) begin
			mem_we = 1'b1;
			mem_wd = rdata_q | (MAP_WORD_BITS'(1) << low_idx);
		end else if (state_q == S_FBIT && rdata_q[bit_q[WB_W-1:0]]) begin
			mem_we = 1'b1;
			mem_wa = {g_q, bit_q[BIT_W-1:WB_W]};
			mem_wd = rdata_q & ~(MAP_WORD_BITS'(1) << bit_q[WB_W-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) map_mem[mem_wa] <= mem_wd;
		rdata_q <= map_mem[mem_ra];
	end

	assign div_start = req_acc && req.req_type == REQ_FREE && req.free_address >= fga_q;

	gba_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (rel_addr),
		.divisor   (bpg_eff),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gc_q  <= 5'd16;
			bpg_q <= 13'd4096;
			fga_q <= '0;
			fgb_q <= 13'd4096;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GROUP_COUNT:  gc_q  <= cfg_data[4:0];
				REG_BLOCKS_PER:   bpg_q <= cfg_data[12:0];
				REG_FIRST_ADDR:   fga_q <= cfg_data[ADDR_W-1:0];
				REG_FINAL_BLOCKS: fgb_q <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < MAX_GROUPS; i++) grp_used_q[i] <= '0;
		end else begin
			// The final step loads the output register itself.
			if (rsp.ready && state_q != S_FIN) out_valid_q <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + MAP_AW'(1);
					if (clr_q == MAP_AW'(MAP_WORDS - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (req_acc) begin
						s_q          <= '0;
						acc_q        <= '0;
						res_grant_q  <= '0;
						res_status_q <= ST_OK;
						tried_q      <= '0;
						g_q          <= req.start_group;
						if (req.req_type == REQ_ALLOC) begin
							state_q <= S_AMOD;
						end else if (req.free_address < fga_q) begin
							res_status_q <= ST_BAD_ADDR;
							state_q      <= S_SUM;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_AMOD: begin
					// Start group modulo the group count, by repeated subtraction.
					if (GCNT_W'(g_q) >= n_eff) g_q <= GRP_W'(GCNT_W'(g_q) - n_eff);
					else state_q <= S_AGRP;
				end
				S_AGRP: begin
					word_q <= '0;
					base_q <= fga_q + ADDR_W'(grp_off);
					if (used_cur >= cap_cur) begin
						if (last_group) begin
							res_status_q <= ST_NO_SPACE;
							state_q      <= S_SUM;
						end else begin
							tried_q <= tried_q + GCNT_W'(1);
							g_q     <= (GCNT_W'(g_q) + GCNT_W'(1) == n_eff) ? '0
								: g_q + GRP_W'(1);
						end
					end else begin
						state_q <= S_ARD;
					end
				end
				S_ARD: state_q <= S_ACHK;
				S_ACHK: begin
					if (found) begin
						grp_used_q[g_q] <= grp_used_q[g_q] + CNT_W'(1);
						res_grant_q     <= base_q + ADDR_W'({word_q, low_idx});
						state_q         <= S_SUM;
					end else if (!last_word) begin
						word_q  <= word_q + WIDX_W'(1);
						state_q <= S_ARD;
					end else if (last_group) begin
						res_status_q <= ST_NO_SPACE;
						state_q      <= S_SUM;
					end else begin
						tried_q <= tried_q + GCNT_W'(1);
						g_q     <= (GCNT_W'(g_q) + GCNT_W'(1) == n_eff) ? '0 : g_q + GRP_W'(1);
						state_q <= S_AGRP;
					end
				end
				S_DIV: begin
					if (div_done) begin
						g_q     <= div_quo[GRP_W-1:0];
						bit_q   <= div_rem[BIT_W-1:0];
						state_q <= quo_ok ? S_FCHK : S_SUM;
						if (!quo_ok) res_status_q <= ST_BAD_ADDR;
					end
				end
				S_FCHK: begin
					if (CNT_W'(bit_q) >= cap_cur || div_rem >= cap_cur) begin
						res_status_q <= ST_BAD_ADDR;
						state_q      <= S_SUM;
					end else begin
						state_q <= S_FRD;
					end
				end
				S_FRD: state_q <= S_FBIT;
				S_FBIT: begin
					if (!rdata_q[bit_q[WB_W-1:0]]) begin
						res_status_q <= ST_DOUBLE_FREE;
					end else if (grp_used_q[g_q] != '0) begin
						grp_used_q[g_q] <= grp_used_q[g_q] - CNT_W'(1);
					end
					state_q <= S_SUM;
				end
				S_SUM: begin
					// One group per cycle: add its free blocks, floored at zero.
					if (cap_cur > used_cur) acc_q <= acc_q + TOT_W'(cap_cur - used_cur);
					s_q <= s_q + GCNT_W'(1);
					if (s_q + GCNT_W'(1) == n_eff) state_q <= S_FIN;
				end
				S_FIN: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_grant_q  <= res_grant_q;
						out_total_q  <= acc_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req.ready           = state_q == S_IDLE;
	assign rsp.valid           = out_valid_q;
	assign rsp.status          = out_status_q;
	assign rsp.granted_address = out_grant_q;
	assign rsp.free_total      = out_total_q;

	// An accepted item always leaves the idle state.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> state_q != S_IDLE) else $error("item accepted but sequencer idle");

	// A failed request never grants an address.
	a_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != ST_OK) |-> rsp.granted_address == '0)
		else $error("address granted on a failed request");

	// The map write on a scan happens only with a clear bit found.
	a_scan_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ACHK && mem_we) |-> found) else $error("map written without a free bit");

endmodule

// ===== sim/grouped_bitmap_block_allocator_test.sv =====
// Self-checking testbench of the grouped bitmap block allocator.
module grouped_bitmap_block_allocator_test;
	import gba_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		status_t           st;
		logic [ADDR_W-1:0] granted;
		logic [TOT_W-1:0]  free_cnt;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CIDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	gba_req_if req ();
	gba_rsp_if rsp ();

	grouped_bitmap_block_allocator i_dut (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Shadow registers and allocator state of the predictor.
	logic [4:0]        sh_groups;
	logic [12:0]       sh_bpg;
	logic [ADDR_W-1:0] sh_first;
	logic [12:0]       sh_final;
	bit                blk_used [MAX_GROUPS][MAX_GROUP_BLOCKS];
	int unsigned       grp_used [MAX_GROUPS];

	outcome_t          pending_results[$];
	logic [ADDR_W-1:0] granted_pool[$];
	int                errors = 0;
	int                rx_hold = 0;
	bit                quiet = 1'b0;

	function automatic int unsigned groups_in_use();
		if (sh_groups == 0) return 1;
		if (sh_groups > MAX_GROUPS) return MAX_GROUPS;
		return sh_groups;
	endfunction

	function automatic int unsigned bpg_in_use();
		if (sh_bpg == 0) return 1;
		if (sh_bpg > MAX_GROUP_BLOCKS) return MAX_GROUP_BLOCKS;
		return sh_bpg;
	endfunction

	function automatic int unsigned group_cap(int unsigned g);
		int unsigned f;
		f = (sh_final == 0) ? 1 : sh_final;
		if (g + 1 == groups_in_use() && f < bpg_in_use()) return f;
		return bpg_in_use();
	endfunction

	// Works out the result of one request and updates the allocator state.
	function automatic outcome_t allocate_or_free(logic kind, logic [3:0] sg,
			logic [ADDR_W-1:0] addr);
		outcome_t o;
		int unsigned n, bpg, g, c, sum;
		longint unsigned rel;
		bit found;
		n = groups_in_use();
		bpg = bpg_in_use();
		o.st = ST_OK;
		o.granted = '0;
		found = 1'b0;
		if (kind == REQ_ALLOC) begin
			for (int i = 0; i < n && !found; i++) begin
				g = (sg % n + i) % n;
				c = group_cap(g);
				if (grp_used[g] >= c) continue;
				for (int b = 0; b < c; b++) begin
					if (!blk_used[g][b]) begin
						blk_used[g][b] = 1'b1;
						grp_used[g]++;
						o.granted = sh_first + ADDR_W'(g * bpg + b);
						found = 1'b1;
						break;
					end
				end
			end
			if (!found) o.st = ST_NO_SPACE;
		end else if (addr < sh_first) begin
			o.st = ST_BAD_ADDR;
		end else begin
			rel = addr - sh_first;
			if (rel / bpg >= n || rel % bpg >= group_cap(rel / bpg)) begin
				o.st = ST_BAD_ADDR;
			end else begin
				g = rel / bpg;
				c = rel % bpg;
				if (!blk_used[g][c]) begin
					o.st = ST_DOUBLE_FREE;
				end else begin
					blk_used[g][c] = 1'b0;
					if (grp_used[g] > 0) grp_used[g]--;
				end
			end
		end
		sum = 0;
		for (int i = 0; i < n; i++)
			if (grp_used[i] < group_cap(i)) sum += group_cap(i) - grp_used[i];
		o.free_cnt = TOT_W'(sum);
		return o;
	endfunction

	// Random gap length: mostly none or short, a few long.
	function automatic int gap_len();
		int r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Receiver side: random stalls, plus long hold-offs on request.
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			rsp.ready = 1'b0;
			rx_hold--;
		end else if (quiet) begin
			rsp.ready = 1'b1;
		end else if ($urandom_range(0, 199) == 0) begin
			rx_hold = $urandom_range(20, 60);
			rsp.ready = 1'b0;
		end else begin
			rsp.ready = ($urandom_range(0, 99) < 75);
		end
	end

	// Compares each accepted result with the oldest expectation.
	always @(posedge clk) begin
		outcome_t e;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_results.size() == 0) begin
				$error("result with no request outstanding");
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (rsp.status !== e.st) begin
					$error("status expected %0d actual %0d", e.st, rsp.status);
					errors++;
				end
				if (rsp.granted_address !== e.granted) begin
					$error("granted_address expected %h actual %h", e.granted,
						rsp.granted_address);
					errors++;
				end
				if (rsp.free_total !== e.free_cnt) begin
					$error("free_total expected %0d actual %0d", e.free_cnt,
						rsp.free_total);
					errors++;
				end
			end
		end
	end

	// Offers one item, waits for acceptance, predicts it, then may idle a while.
	task automatic send_item(logic kind, logic [3:0] sg, logic [ADDR_W-1:0] addr);
		outcome_t o;
		int gap;
		req.valid = 1'b1;
		req.req_type = kind;
		req.start_group = sg;
		req.free_address = addr;
		do @(posedge clk); while (!req.ready);
		o = allocate_or_free(kind, sg, addr);
		pending_results.push_back(o);
		if (kind == REQ_ALLOC && o.st == ST_OK) granted_pool.push_back(o.granted);
		@(negedge clk);
		gap = gap_len();
		if (gap > 0) begin
			req.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic drain();
		req.valid = 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	// Register writes happen only with the block idle.
	task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] value);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_GROUP_COUNT:  sh_groups = value[4:0];
			REG_BLOCKS_PER:   sh_bpg = value[12:0];
			REG_FIRST_ADDR:   sh_first = value[ADDR_W-1:0];
			REG_FINAL_BLOCKS: sh_final = value[12:0];
			default: ;
		endcase
	endtask

	task automatic set_volume(logic [4:0] gc, logic [12:0] bpg, logic [ADDR_W-1:0] first,
			logic [12:0] fgb);
		drain();
		write_reg(REG_GROUP_COUNT, CFG_W'(gc));
		write_reg(REG_BLOCKS_PER, CFG_W'(bpg));
		write_reg(REG_FIRST_ADDR, CFG_W'(first));
		write_reg(REG_FINAL_BLOCKS, CFG_W'(fgb));
	endtask

	function automatic logic [ADDR_W-1:0] rand_addr();
		return {$urandom, $urandom};
	endfunction

	// Default volume: extremes of start group and address, double free, bad range.
	task automatic test_default_volume();
		send_item(REQ_ALLOC, 4'd0, '0);
		send_item(REQ_ALLOC, 4'd15, '1);
		send_item(REQ_FREE, 4'd0, 48'd0);
		send_item(REQ_FREE, 4'd0, 48'd0);
		send_item(REQ_FREE, 4'd0, 48'd65535);
		send_item(REQ_FREE, 4'd0, 48'd65536);
		send_item(REQ_FREE, 4'hf, '1);
	endtask

	// Tiny volume near the top of the address space: wrap, no space, low address.
	task automatic test_tiny_volume();
		set_volume(5'd2, 13'd3, '1 - 48'd1, 13'd1);
		for (int i = 0; i < 5; i++) send_item(REQ_ALLOC, 4'(i * 7), '0);
		send_item(REQ_FREE, 4'd0, 48'd1);
		send_item(REQ_FREE, 4'd0, '1);
		send_item(REQ_FREE, 4'd0, '1 - 48'd2);
		send_item(REQ_ALLOC, 4'd1, '0);
	endtask

	// Registers out of range are clamped; shrinking leaves groups over capacity.
	task automatic test_register_clamps();
		set_volume(5'd0, 13'd0, 48'd100, 13'd0);
		send_item(REQ_ALLOC, 4'd9, '0);
		send_item(REQ_ALLOC, 4'd3, '0);
		send_item(REQ_FREE, 4'd0, 48'd100);
		set_volume(5'd31, 13'h1fff, 48'd0, 13'h1fff);
		send_item(REQ_ALLOC, 4'd5, '0);
		send_item(REQ_ALLOC, 4'd5, '0);
		set_volume(5'd6, 13'd2, 48'd0, 13'd1);
		send_item(REQ_ALLOC, 4'd0, '0);
		send_item(REQ_FREE, 4'd0, 48'd11);
	endtask

	// Random mix of allocations and frees, mostly of granted blocks.
	task automatic test_random_phase(int count);
		logic [ADDR_W-1:0] a;
		int r, k;
		logic [12:0] bpg;
		bpg = ($urandom_range(0, 4) == 0) ? 13'($urandom_range(0, 8191))
			: 13'($urandom_range(1, 64));
		set_volume(5'($urandom_range(0, 31)), bpg,
			($urandom_range(0, 2) == 0) ? rand_addr() : 48'($urandom_range(0, 1000)),
			13'($urandom_range(0, 80)));
		granted_pool.delete();
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 55) begin
				send_item(REQ_ALLOC, 4'($urandom), rand_addr());
			end else if (r < 85 && granted_pool.size() != 0) begin
				k = $urandom_range(0, granted_pool.size() - 1);
				a = granted_pool[k];
				if ($urandom_range(0, 4) != 0) granted_pool.delete(k);
				send_item(REQ_FREE, 4'($urandom), a);
			end else if (r < 93) begin
				send_item(REQ_FREE, 4'($urandom),
					sh_first + 48'($urandom_range(0, 20 * bpg_in_use())) - 48'd2);
			end else begin
				send_item(REQ_FREE, 4'($urandom), rand_addr());
			end
		end
	endtask

	// The receiver holds off while items keep coming, so the input stalls.
	task automatic test_backpressure();
		drain();
		quiet = 1'b1;
		rx_hold = 600;
		for (int i = 0; i < 12; i++) send_item(REQ_ALLOC, 4'($urandom), '0);
		for (int i = 0; i < 6; i++)
			send_item(REQ_FREE, 4'd0, (i < granted_pool.size()) ? granted_pool[i] : rand_addr());
		quiet = 1'b0;
	endtask

	initial begin
		req.valid = 1'b0;
		req.req_type = REQ_ALLOC;
		req.start_group = '0;
		req.free_address = '0;
		rsp.ready = 1'b0;
		sh_groups = 5'd16;
		sh_bpg = 13'd4096;
		sh_first = '0;
		sh_final = 13'd4096;
		foreach (grp_used[g]) grp_used[g] = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		test_default_volume();
		test_tiny_volume();
		test_register_clamps();
		for (int p = 0; p < 6; p++) begin
			quiet = (p == 2);
			test_random_phase(95);
			if (p == 3) test_backpressure();
		end
		req.valid = 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (2200) @(negedge clk);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// Run limit.
	initial begin
		#50ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/gba_pkg.sv
src/gba_if.sv
src/gba_div.sv
src/grouped_bitmap_block_allocator.sv
sim/grouped_bitmap_block_allocator_test.sv
